/* design/ack_handshake_frame_link_core_assert.svh */
// Assertion macros used by the frame link datapath.
`ifndef ACK_HANDSHAKE_FRAME_LINK_CORE_ASSERT_SVH
`define ACK_HANDSHAKE_FRAME_LINK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define AHFL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AHFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ahfl_pkg.sv */
`timescale 1ns / 1ps
// Package: types, constants and control structs of the frame link.
package ahfl_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int OVERHEAD    = 3;
  localparam int TX_CAP      = FRAME_DEPTH - OVERHEAD;

  localparam int CNT_W     = 7;
  localparam int TMO_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam logic [7:0]       START_CODE  = 8'h01;
  localparam logic [7:0]       ACK_CODE    = 8'h55;
  localparam logic [TMO_W-1:0] ELAPSED_MAX = 13'd8191;
  localparam logic [TMO_W-1:0] TMO_RESET   = 13'd5000;
  localparam logic [CNT_W-1:0] MAXLEN_RST  = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAXLEN  = 2'd1;

  typedef enum logic [1:0] {
    FN_LINE = 2'd0,
    FN_TICK = 2'd1,
    FN_TX   = 2'd2,
    FN_READ = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KD_LINE   = 2'd0,
    KD_HOST   = 2'd1,
    KD_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_PKT  = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_BAD     = 3'd3,
    ST_BUSY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_DATA    = 3'd2,
    PH_READY   = 3'd3,
    PH_TIMEOUT = 3'd4,
    PH_ERROR   = 3'd5
  } rx_phase_t;

  typedef enum logic [2:0] {
    PLAN_NONE,
    PLAN_ONE,
    PLAN_TX_HDR,
    PLAN_TX_BODY,
    PLAN_RX_BODY
  } plan_t;

  typedef enum logic [2:0] {
    SRC_ONE,
    SRC_TX_START,
    SRC_TX_LEN,
    SRC_TX_BYTE,
    SRC_TX_SUM,
    SRC_RX_BYTE,
    SRC_RX_OK
  } out_src_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_EXEC,
    CS_TX_LEN,
    CS_TX_RD,
    CS_TX_LOAD,
    CS_TX_SUM,
    CS_RX_RD,
    CS_RX_LOAD,
    CS_RX_END
  } ctrl_state_t;

  typedef struct packed {
    logic     latch;
    logic     commit;
    logic     idx_init_tx;
    logic     idx_init_rx;
    logic     idx_inc;
    logic     tx_rd;
    logic     rx_rd;
    logic     load;
    out_src_t src;
    logic     tx_done;
    logic     rx_done;
  } ahfl_cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  tx_more;
    logic  rx_more;
    logic  out_free;
  } ahfl_stat_t;

endpackage

/* design/ahfl_in_if.sv */
`timescale 1ns / 1ps
// Interface: input request channel of the frame link.
interface ahfl_in_if import ahfl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       last_flag;

  modport source(output valid, func, data_byte, last_flag, input ready);
  modport sink(input valid, func, data_byte, last_flag, output ready);
endinterface

/* design/ahfl_out_if.sv */
`timescale 1ns / 1ps
// Interface: result channel of the frame link.
interface ahfl_out_if import ahfl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       run_end;

  modport source(output valid, kind, out_byte, status, run_end, input ready);
  modport sink(input valid, kind, out_byte, status, run_end, output ready);
endinterface

/* design/ahfl_cfg_if.sv */
`timescale 1ns / 1ps
// Interface: configuration write channel of the frame link.
interface ahfl_cfg_if import ahfl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* design/ahfl_ram.sv */
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module ahfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/ahfl_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences one request and its results over the datapath.
module ahfl_ctrl import ahfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ahfl_stat_t stat,
  output ahfl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    cmd.latch       = 1'b0;
    cmd.commit      = 1'b0;
    cmd.idx_init_tx = 1'b0;
    cmd.idx_init_rx = 1'b0;
    cmd.idx_inc     = 1'b0;
    cmd.tx_rd       = 1'b0;
    cmd.rx_rd       = 1'b0;
    cmd.load        = 1'b0;
    cmd.src         = SRC_ONE;
    cmd.tx_done     = 1'b0;
    cmd.rx_done     = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = CS_EXEC;
        end
      end
      CS_EXEC: begin
        case (stat.plan)
          PLAN_NONE: begin
            cmd.commit = 1'b1;
            state_nxt  = CS_IDLE;
          end
          PLAN_ONE: begin
            if (stat.out_free) begin
              cmd.load   = 1'b1;
              cmd.src    = SRC_ONE;
              cmd.commit = 1'b1;
              state_nxt  = CS_IDLE;
            end
          end
          PLAN_TX_HDR: begin
            if (stat.out_free) begin
              cmd.load   = 1'b1;
              cmd.src    = SRC_TX_START;
              cmd.commit = 1'b1;
              state_nxt  = CS_TX_LEN;
            end
          end
          PLAN_TX_BODY: begin
            cmd.idx_init_tx = 1'b1;
            state_nxt       = CS_TX_RD;
          end
          PLAN_RX_BODY: begin
            cmd.idx_init_rx = 1'b1;
            state_nxt       = CS_RX_RD;
          end
          default: begin
            state_nxt = CS_IDLE;
          end
        endcase
      end
      CS_TX_LEN: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          cmd.src   = SRC_TX_LEN;
          state_nxt = CS_IDLE;
        end
      end
      CS_TX_RD: begin
        if (stat.tx_more) begin
          cmd.tx_rd = 1'b1;
          state_nxt = CS_TX_LOAD;
        end else begin
          state_nxt = CS_TX_SUM;
        end
      end
      CS_TX_LOAD: begin
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.src     = SRC_TX_BYTE;
          cmd.idx_inc = 1'b1;
          state_nxt   = CS_TX_RD;
        end
      end
      CS_TX_SUM: begin
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.src     = SRC_TX_SUM;
          cmd.tx_done = 1'b1;
          state_nxt   = CS_IDLE;
        end
      end
      CS_RX_RD: begin
        if (stat.rx_more) begin
          cmd.rx_rd = 1'b1;
          state_nxt = CS_RX_LOAD;
        end else begin
          state_nxt = CS_RX_END;
        end
      end
      CS_RX_LOAD: begin
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.src     = SRC_RX_BYTE;
          cmd.idx_inc = 1'b1;
          state_nxt   = CS_RX_RD;
        end
      end
      CS_RX_END: begin
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.src     = SRC_RX_OK;
          cmd.rx_done = 1'b1;
          state_nxt   = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

/* design/ahfl_dp.sv */
`timescale 1ns / 1ps
// Datapath: link state, frame stores, configuration and the result register.
`include "ack_handshake_frame_link_core_assert.svh"
module ahfl_dp import ahfl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_flag,
  input  ahfl_cmd_t   cmd,
  output ahfl_stat_t  stat,
  ahfl_out_if.source  out_ch,
  ahfl_cfg_if.sink    cfg_ch
);

  // latched request
  func_t      func_r;
  logic [7:0] byte_r;
  logic       last_r;

  // configuration
  logic [TMO_W-1:0] timeout_r, timeout_nxt;
  logic [CNT_W-1:0] maxlen_r, maxlen_nxt;

  // link state
  rx_phase_t        rx_phase_r, rx_phase_nxt;
  logic [CNT_W-1:0] rx_count_r, rx_count_nxt;
  logic [CNT_W-1:0] rx_len_r, rx_len_nxt;
  logic [7:0]       rx_sum_r, rx_sum_nxt;
  logic [TMO_W-1:0] elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0] tx_count_r, tx_count_nxt;
  logic [7:0]       tx_sum_r, tx_sum_nxt;
  logic             tx_pend_r, tx_pend_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r;
  logic [7:0] out_byte_r;
  logic [2:0] out_status_r;
  logic       out_end_r;

  logic             timed_out, len_ok, rx_active;
  logic [CNT_W-1:0] rx_count_inc;
  logic [7:0]       rx_sum_add;
  logic [TMO_W-1:0] elapsed_inc;
  logic             tx_we, rx_we;
  logic [7:0]       tx_rdata, rx_rdata;
  kind_t            one_kind;
  logic [7:0]       one_byte;
  status_t          one_status;
  kind_t            o_kind;
  logic [7:0]       o_byte;
  status_t          o_status;
  logic             o_end;
  logic [7:0]       tx_check;
  logic             cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  assign rx_active    = (rx_phase_r == PH_LEN) || (rx_phase_r == PH_DATA);
  assign timed_out    = rx_active && (elapsed_r > timeout_r);
  assign len_ok       = (byte_r >= 8'(OVERHEAD)) && (byte_r <= {1'b0, maxlen_r})
                        && (byte_r <= 8'(FRAME_DEPTH));
  assign rx_count_inc = rx_count_r + 7'd1;
  assign rx_sum_add   = rx_sum_r + byte_r;
  assign elapsed_inc  = (elapsed_r < ELAPSED_MAX) ? elapsed_r + 13'd1 : elapsed_r;
  assign tx_check     = 8'd0 - (8'(OVERHEAD + 1) + {1'b0, tx_count_r} + tx_sum_r);

  assign tx_we = cmd.commit && (func_r == FN_TX) && !tx_pend_r
                 && (tx_count_r < CNT_W'(TX_CAP));
  assign rx_we = cmd.commit && (func_r == FN_LINE) && !tx_pend_r && !timed_out
                 && (rx_phase_r == PH_DATA) && (rx_count_r < CNT_W'(FRAME_DEPTH));

  ahfl_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_count_r[ADDR_W-1:0]),
    .wdata (byte_r),
    .re    (cmd.tx_rd),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (tx_rdata)
  );

  ahfl_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_count_r[ADDR_W-1:0]),
    .wdata (byte_r),
    .re    (cmd.rx_rd),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rx_rdata)
  );

  // plan, status flags and single-result value for the latched request
  always_comb begin
    stat.plan     = PLAN_NONE;
    stat.tx_more  = idx_r < tx_count_r;
    stat.rx_more  = (idx_r + 7'd1) < rx_len_r;
    stat.out_free = !out_valid_r || out_ch.ready;
    one_kind      = KD_STATUS;
    one_byte      = 8'd0;
    one_status    = ST_OK;
    case (func_r)
      FN_LINE: begin
        one_kind = KD_LINE;
        one_byte = ACK_CODE;
        if (tx_pend_r) begin
          if (byte_r == ACK_CODE) begin
            stat.plan = PLAN_TX_BODY;
          end
        end else if (!timed_out && (rx_phase_r == PH_LEN) && len_ok) begin
          stat.plan = PLAN_ONE;
        end
      end
      FN_TICK: begin
        stat.plan = PLAN_NONE;
      end
      FN_TX: begin
        one_status = ST_BUSY;
        if (tx_pend_r) begin
          stat.plan = PLAN_ONE;
        end else if (last_r) begin
          stat.plan = PLAN_TX_HDR;
        end
      end
      FN_READ: begin
        case (rx_phase_r)
          PH_READY:   stat.plan = PLAN_RX_BODY;
          PH_TIMEOUT: begin
            stat.plan  = PLAN_ONE;
            one_status = ST_TIMEOUT;
          end
          PH_ERROR: begin
            stat.plan  = PLAN_ONE;
            one_status = ST_BAD;
          end
          default: begin
            stat.plan  = PLAN_ONE;
            one_status = ST_NO_PKT;
          end
        endcase
      end
      default: begin
        stat.plan = PLAN_NONE;
      end
    endcase
  end

  // state update
  always_comb begin
    timeout_nxt  = timeout_r;
    maxlen_nxt   = maxlen_r;
    rx_phase_nxt = rx_phase_r;
    rx_count_nxt = rx_count_r;
    rx_len_nxt   = rx_len_r;
    rx_sum_nxt   = rx_sum_r;
    elapsed_nxt  = elapsed_r;
    tx_count_nxt = tx_count_r;
    tx_sum_nxt   = tx_sum_r;
    tx_pend_nxt  = tx_pend_r;
    idx_nxt      = idx_r;

    if (cfg_we) begin
      if (cfg_ch.index == REG_TIMEOUT) begin
        timeout_nxt = cfg_ch.data[TMO_W-1:0];
      end else if (cfg_ch.index == REG_MAXLEN) begin
        maxlen_nxt = cfg_ch.data[CNT_W-1:0];
      end
    end

    if (cmd.commit) begin
      case (func_r)
        FN_LINE: begin
          if (!tx_pend_r) begin
            if (timed_out) begin
              rx_phase_nxt = PH_TIMEOUT;
            end else begin
              case (rx_phase_r)
                PH_HUNT: begin
                  if (byte_r == START_CODE) begin
                    rx_count_nxt = 7'd1;
                    rx_sum_nxt   = START_CODE;
                    elapsed_nxt  = '0;
                    rx_phase_nxt = PH_LEN;
                  end
                end
                PH_LEN: begin
                  if (len_ok) begin
                    rx_len_nxt   = byte_r[CNT_W-1:0];
                    rx_count_nxt = 7'd2;
                    rx_sum_nxt   = rx_sum_add;
                    rx_phase_nxt = PH_DATA;
                  end else begin
                    rx_phase_nxt = PH_ERROR;
                  end
                end
                PH_DATA: begin
                  rx_count_nxt = rx_count_inc;
                  rx_sum_nxt   = rx_sum_add;
                  if (rx_count_inc >= rx_len_r) begin
                    rx_phase_nxt = (rx_sum_add == 8'd0) ? PH_READY : PH_ERROR;
                  end
                end
                default: begin
                  rx_phase_nxt = rx_phase_r;
                end
              endcase
            end
          end
        end
        FN_TICK: begin
          if (rx_active) begin
            elapsed_nxt = elapsed_inc;
            if (!tx_pend_r && (elapsed_inc > timeout_r)) begin
              rx_phase_nxt = PH_TIMEOUT;
            end
          end
        end
        FN_TX: begin
          if (!tx_pend_r) begin
            if (tx_count_r < CNT_W'(TX_CAP)) begin
              tx_count_nxt = tx_count_r + 7'd1;
              tx_sum_nxt   = tx_sum_r + byte_r;
            end
            if (last_r) begin
              tx_pend_nxt = 1'b1;
            end
          end
        end
        FN_READ: begin
          if ((rx_phase_r == PH_TIMEOUT) || (rx_phase_r == PH_ERROR)) begin
            rx_phase_nxt = PH_HUNT;
          end
        end
        default: begin
          rx_phase_nxt = rx_phase_r;
        end
      endcase
    end

    if (cmd.tx_done) begin
      tx_count_nxt = '0;
      tx_sum_nxt   = '0;
      tx_pend_nxt  = 1'b0;
    end
    if (cmd.rx_done) begin
      rx_phase_nxt = PH_HUNT;
    end

    if (cmd.idx_init_tx) begin
      idx_nxt = '0;
    end else if (cmd.idx_init_rx) begin
      idx_nxt = 7'd2;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + 7'd1;
    end
  end

  // result selection
  always_comb begin
    o_kind   = KD_LINE;
    o_byte   = 8'd0;
    o_status = ST_OK;
    o_end    = 1'b0;
    case (cmd.src)
      SRC_ONE: begin
        o_kind   = one_kind;
        o_byte   = (one_kind == KD_LINE) ? one_byte : 8'd0;
        o_status = (one_kind == KD_STATUS) ? one_status : ST_OK;
        o_end    = 1'b1;
      end
      SRC_TX_START: o_byte = START_CODE;
      SRC_TX_LEN: begin
        o_byte = {1'b0, tx_count_r} + 8'(OVERHEAD);
        o_end  = 1'b1;
      end
      SRC_TX_BYTE:  o_byte = tx_rdata;
      SRC_TX_SUM: begin
        o_byte = tx_check;
        o_end  = 1'b1;
      end
      SRC_RX_BYTE: begin
        o_kind = KD_HOST;
        o_byte = rx_rdata;
      end
      SRC_RX_OK: begin
        o_kind = KD_STATUS;
        o_end  = 1'b1;
      end
      default: begin
        o_end = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TMO_RESET;
      maxlen_r    <= MAXLEN_RST;
      rx_phase_r  <= PH_HUNT;
      rx_count_r  <= '0;
      rx_len_r    <= '0;
      rx_sum_r    <= '0;
      elapsed_r   <= '0;
      tx_count_r  <= '0;
      tx_sum_r    <= '0;
      tx_pend_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      timeout_r   <= timeout_nxt;
      maxlen_r    <= maxlen_nxt;
      rx_phase_r  <= rx_phase_nxt;
      rx_count_r  <= rx_count_nxt;
      rx_len_r    <= rx_len_nxt;
      rx_sum_r    <= rx_sum_nxt;
      elapsed_r   <= elapsed_nxt;
      tx_count_r  <= tx_count_nxt;
      tx_sum_r    <= tx_sum_nxt;
      tx_pend_r   <= tx_pend_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= func_t'(in_func);
      byte_r <= in_data_byte;
      last_r <= in_last_flag;
    end
    if (cmd.load) begin
      out_kind_r   <= o_kind;
      out_byte_r   <= o_byte;
      out_status_r <= o_status;
      out_end_r    <= o_end;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.run_end  = out_end_r;

  `AHFL_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.load, stat.out_free, "result overwritten")
  `AHFL_ASSERT_IMPL(a_tx_cap, clk, rst_n, 1'b1, tx_count_r <= CNT_W'(TX_CAP), "tx count overflow")
  `AHFL_ASSERT_IMPL(a_rx_data, clk, rst_n, rx_phase_r == PH_DATA, rx_count_r < rx_len_r, "rx count past length")
  `AHFL_ASSERT_IMPL(a_rx_rd, clk, rst_n, cmd.rx_rd, rx_phase_r == PH_READY, "rx read without frame")
  `AHFL_ASSERT_IMPL(a_tx_rd, clk, rst_n, cmd.tx_rd, tx_pend_r, "tx read without pending frame")

endmodule

/* design/ack_handshake_frame_link_core.sv */
`timescale 1ns / 1ps
// Top level: start/length/checksum frame link with acknowledge handshake.
// in_ch takes one request per handshake: a line byte, a ms tick, a host
// payload byte (last_flag ends the frame) or a host read. out_ch returns the
// results of a request in order, run_end set on the last one. cfg_ch writes
// timeout_ms (index 0) and max_frame_len (index 1) and is always ready.
// A request is latched when taken and executed in the execute state, which
// waits for a free output register where it loads a result. A stored run
// is sent byte by byte through the registered read of the frame store,
// each byte read only once the last is loaded: an ack starting the transmit
// sends n payload bytes and a checksum, a read of a ready frame L - 3 bytes.
// Results leave through one output register; the next request is taken
// while the last result still waits there. When out_ch stalls the block
// holds its place in the run until the register is free.
// Reset (rst_n low at a clock edge) clears the link state and restores
// the register defaults; the frame stores are not cleared, since only
// entries written since then are read.
module ack_handshake_frame_link_core import ahfl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  ahfl_in_if.sink    in_ch,
  ahfl_out_if.source out_ch,
  ahfl_cfg_if.sink   cfg_ch
);

  ahfl_cmd_t  cmd;
  ahfl_stat_t stat;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  ahfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ahfl_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_ch.func),
    .in_data_byte (in_ch.data_byte),
    .in_last_flag (in_ch.last_flag),
    .cmd          (cmd),
    .stat         (stat),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch)
  );

endmodule

/* tb/sv/ack_handshake_frame_link_core_tb.sv */
`timescale 1ns / 1ps
// Testbench: frame link core driven by random request bursts, checked against a link predictor.
module ack_handshake_frame_link_core_tb import ahfl_pkg::*; ();

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 30;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_byte;
    logic       last_flag;
  } link_req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    status_t    status;
    logic       run_end;
  } link_res_t;

  logic clk;
  logic rst_n;

  ahfl_in_if  in_ch();
  ahfl_out_if out_ch();
  ahfl_cfg_if cfg_ch();

  ack_handshake_frame_link_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  link_req_t req_feed_q[$];
  link_res_t link_out_q[$];
  int        n_fed;
  int        n_taken;
  int        mismatch_cnt;
  int        quiet_cycles;
  bit        gaps_on;
  bit        stall_on;
  int        hold_asks;
  int        cur_tmo;
  int        cur_max;

  // link state as the predictor sees it
  rx_phase_t   rx_ph;
  logic [7:0]  rx_mem [FRAME_DEPTH];
  logic [6:0]  rx_cnt;
  logic [6:0]  rx_len;
  logic [7:0]  rx_sum;
  logic [12:0] ms_elapsed;
  logic [7:0]  tx_mem [FRAME_DEPTH];
  logic [6:0]  tx_cnt;
  logic [7:0]  tx_sum;
  logic        tx_busy;
  logic        tx_wait;
  logic [12:0] tmo_lim;
  logic [6:0]  max_len;
  link_res_t   staged;
  bit          staged_ok;

  task automatic flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // last result of a run is held back so run_end can be set on it
  function automatic void emit(kind_t k, logic [7:0] v, status_t s);
    if (staged_ok) begin
      link_out_q.push_back(staged);
    end
    staged    = '{k, v, s, 1'b0};
    staged_ok = 1'b1;
  endfunction

  function automatic bit rx_late();
    return (rx_ph == PH_LEN || rx_ph == PH_DATA) && ms_elapsed > tmo_lim;
  endfunction

  task automatic link_step(link_req_t r);
    logic [7:0] b;
    logic [7:0] chk;
    int         i;
    b = r.data_byte;
    case (r.func)
      FN_LINE: begin
        if (tx_busy) begin
          if (tx_wait && b == ACK_CODE) begin
            chk = START_CODE + 8'(tx_cnt) + 8'(OVERHEAD) + tx_sum;
            for (i = 0; i < tx_cnt; i++) begin
              emit(KD_LINE, tx_mem[i], ST_OK);
            end
            emit(KD_LINE, 8'(~chk + 8'd1), ST_OK);
            tx_busy = 1'b0;
            tx_wait = 1'b0;
            tx_cnt  = '0;
            tx_sum  = '0;
          end
        end else if (rx_late()) begin
          rx_ph = PH_TIMEOUT;
        end else begin
          case (rx_ph)
            PH_HUNT: begin
              if (b == START_CODE) begin
                rx_mem[0]  = b;
                rx_cnt     = 7'd1;
                rx_sum     = b;
                ms_elapsed = '0;
                rx_ph      = PH_LEN;
              end
            end
            PH_LEN: begin
              if (b >= OVERHEAD && b <= max_len && b <= FRAME_DEPTH) begin
                rx_mem[1] = b;
                rx_len    = b[6:0];
                rx_cnt    = 7'd2;
                rx_sum    = rx_sum + b;
                rx_ph     = PH_DATA;
                emit(KD_LINE, ACK_CODE, ST_OK);
              end else begin
                rx_ph = PH_ERROR;
              end
            end
            PH_DATA: begin
              if (rx_cnt < FRAME_DEPTH) begin
                rx_mem[rx_cnt[5:0]] = b;
              end
              rx_cnt = rx_cnt + 7'd1;
              rx_sum = rx_sum + b;
              if (rx_cnt >= rx_len) begin
                rx_ph = (rx_sum == 8'd0) ? PH_READY : PH_ERROR;
              end
            end
            default: ;
          endcase
        end
      end
      FN_TICK: begin
        if (rx_ph == PH_LEN || rx_ph == PH_DATA) begin
          if (ms_elapsed < ELAPSED_MAX) begin
            ms_elapsed = ms_elapsed + 13'd1;
          end
          if (!tx_busy && rx_late()) begin
            rx_ph = PH_TIMEOUT;
          end
        end
      end
      FN_TX: begin
        if (tx_busy) begin
          emit(KD_STATUS, 8'h00, ST_BUSY);
        end else begin
          if (tx_cnt < TX_CAP) begin
            tx_mem[tx_cnt[5:0]] = b;
            tx_cnt              = tx_cnt + 7'd1;
            tx_sum              = tx_sum + b;
          end
          if (r.last_flag) begin
            tx_busy = 1'b1;
            tx_wait = 1'b1;
            emit(KD_LINE, START_CODE, ST_OK);
            emit(KD_LINE, 8'(tx_cnt) + 8'(OVERHEAD), ST_OK);
          end
        end
      end
      default: begin
        case (rx_ph)
          PH_READY: begin
            for (i = 2; i + 1 < rx_len; i++) begin
              emit(KD_HOST, rx_mem[i], ST_OK);
            end
            emit(KD_STATUS, 8'h00, ST_OK);
            rx_ph = PH_HUNT;
          end
          PH_TIMEOUT: begin
            emit(KD_STATUS, 8'h00, ST_TIMEOUT);
            rx_ph = PH_HUNT;
          end
          PH_ERROR: begin
            emit(KD_STATUS, 8'h00, ST_BAD);
            rx_ph = PH_HUNT;
          end
          default: emit(KD_STATUS, 8'h00, ST_NO_PKT);
        endcase
      end
    endcase
    if (staged_ok) begin
      staged.run_end = 1'b1;
      link_out_q.push_back(staged);
      staged_ok = 1'b0;
    end
  endtask

  // request driver: bursts of random length with random gaps when gaps_on is set
  link_req_t nxt;
  int        burst_left;
  int        gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (req_feed_q.size() > 0) begin
        nxt = req_feed_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.func      <= nxt.func;
        in_ch.data_byte <= nxt.data_byte;
        in_ch.last_flag <= nxt.last_flag;
        if (gaps_on) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = $urandom_range(1, 8);
          end
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: rotating stall pattern when stall_on is set, plus long hold-offs on request
  logic [15:0] stall_pat;
  int          hold_seen;
  int          hold_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_pat = 16'hB5A3;
      hold_seen = 0;
      hold_left = 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!stall_on) begin
      out_ch.ready <= 1'b1;
    end else begin
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      if ($urandom_range(0, 63) == 0) begin
        stall_pat = 16'($urandom) | 16'h0101;
      end
      out_ch.ready <= stall_pat[0];
    end
  end

  // monitor: register writes, accepted requests, results
  link_res_t want;
  bit        moved;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ph        = PH_HUNT;
      rx_cnt       = '0;
      rx_len       = '0;
      rx_sum       = '0;
      ms_elapsed   = '0;
      tx_cnt       = '0;
      tx_sum       = '0;
      tx_busy      = 1'b0;
      tx_wait      = 1'b0;
      tmo_lim      = TMO_RESET;
      max_len      = MAXLEN_RST;
      staged_ok    = 1'b0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        if (cfg_ch.index == REG_TIMEOUT) begin
          tmo_lim = cfg_ch.data;
        end else if (cfg_ch.index == REG_MAXLEN) begin
          max_len = cfg_ch.data[6:0];
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        n_taken++;
        link_step('{func_t'(in_ch.func), in_ch.data_byte, in_ch.last_flag});
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (link_out_q.size() == 0) begin
          flag_error($sformatf("result with none due: kind %0d byte %02h status %0d end %0b",
                               out_ch.kind, out_ch.out_byte, out_ch.status, out_ch.run_end));
        end else begin
          want = link_out_q.pop_front();
          if (out_ch.kind !== want.kind) begin
            flag_error($sformatf("kind %0d, want %0d", out_ch.kind, want.kind));
          end
          if (out_ch.out_byte !== want.out_byte) begin
            flag_error($sformatf("out_byte %02h, want %02h", out_ch.out_byte, want.out_byte));
          end
          if (out_ch.status !== want.status) begin
            flag_error($sformatf("status %0d, want %0d", out_ch.status, want.status));
          end
          if (out_ch.run_end !== want.run_end) begin
            flag_error($sformatf("run_end %0b, want %0b", out_ch.run_end, want.run_end));
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("ack_handshake_frame_link_core test failed");
    $finish;
  end

  task automatic queue_req(func_t f, logic [7:0] v, logic l);
    req_feed_q.push_back('{f, v, l});
    n_fed++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_link(int tmo, int maxl);
    cfg_write(REG_TIMEOUT, CFG_DAT_W'(tmo));
    cfg_write(REG_MAXLEN, CFG_DAT_W'(maxl));
    cur_tmo = tmo;
    cur_max = maxl;
  endtask

  task automatic drain();
    while (n_taken != n_fed || link_out_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 4) == 0) begin
      return $urandom_range(3, cur_max);
    end
    return $urandom_range(3, (cur_max < 12) ? cur_max : 12);
  endfunction

  task automatic rx_frame(int len, bit corrupt, int ticks);
    logic [7:0] sum;
    logic [7:0] v;
    int         i;
    sum = START_CODE + 8'(len);
    queue_req(FN_LINE, START_CODE, 1'b0);
    queue_req(FN_LINE, 8'(len), 1'b0);
    for (i = 0; i < len - 2; i++) begin
      if (ticks > 0 && $urandom_range(0, 1) == 0) begin
        queue_req(FN_TICK, 8'($urandom), 1'($urandom));
        ticks--;
      end
      if (i == len - 3) begin
        v = 8'(~sum + 8'd1);
        if (corrupt) begin
          v = v ^ 8'($urandom_range(1, 255));
        end
      end else begin
        v = 8'($urandom);
      end
      sum = sum + v;
      queue_req(FN_LINE, v, 1'($urandom));
    end
    queue_req(FN_READ, 8'($urandom), 1'($urandom));
  endtask

  task automatic tx_frame(int n, int busy, int noise);
    logic [7:0] v;
    int         i;
    for (i = 0; i < n; i++) begin
      queue_req(FN_TX, 8'($urandom), i == n - 1);
    end
    for (i = 0; i < busy; i++) begin
      queue_req(FN_TX, 8'($urandom), 1'($urandom));
    end
    for (i = 0; i < noise; i++) begin
      v = 8'($urandom);
      if (v == ACK_CODE) begin
        v = ~v;
      end
      queue_req(i[0] ? FN_TICK : FN_LINE, v, 1'b0);
    end
    queue_req(FN_LINE, ACK_CODE, 1'($urandom));
  endtask

  task automatic random_sequence();
    int         pick;
    int         len;
    int         k;
    int         i;
    logic [7:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      rx_frame(pick_len(), $urandom_range(0, 6) == 0,
               ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    end else if (pick < 70) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 66) : $urandom_range(1, 8);
      tx_frame(k, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0,
               $urandom_range(0, 2));
    end else if (pick < 80) begin
      // length out of range
      queue_req(FN_LINE, START_CODE, 1'b0);
      case ($urandom_range(0, 2))
        0: v = 8'($urandom_range(0, 2));
        1: v = 8'($urandom_range(cur_max + 1, 255));
        default: v = 8'($urandom_range(FRAME_DEPTH + 1, 255));
      endcase
      queue_req(FN_LINE, v, 1'b0);
      k = $urandom_range(0, 3);
      for (i = 0; i < k; i++) begin
        queue_req(FN_LINE, 8'($urandom), 1'($urandom));
      end
      queue_req(FN_READ, 8'($urandom), 1'($urandom));
    end else if (pick < 88) begin
      // frame left incomplete while ms ticks arrive, enough to time out when the timeout is short
      len = pick_len();
      queue_req(FN_LINE, START_CODE, 1'b0);
      queue_req(FN_LINE, 8'(len), 1'b0);
      k = $urandom_range(0, len - 3);
      for (i = 0; i < k; i++) begin
        queue_req(FN_LINE, 8'($urandom), 1'($urandom));
      end
      k = (cur_tmo < 40) ? cur_tmo + $urandom_range(1, 3) : $urandom_range(1, 4);
      for (i = 0; i < k; i++) begin
        queue_req(FN_TICK, 8'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 1) == 0) begin
        queue_req(FN_LINE, 8'($urandom), 1'b0);
      end
      queue_req(FN_READ, 8'($urandom), 1'($urandom));
    end else begin
      k = $urandom_range(1, 6);
      for (i = 0; i < k; i++) begin
        queue_req(func_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  int ph;
  int i;
  int phase_start;

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FN_LINE;
    in_ch.data_byte = 8'h00;
    in_ch.last_flag = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_TIMEOUT;
    cfg_ch.data     = '0;
    gaps_on         = 1'b1;
    stall_on        = 1'b1;
    hold_asks       = 0;
    cur_tmo         = TMO_RESET;
    cur_max         = MAXLEN_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: read with nothing held, empty payload, bad length,
    // bad checksum, transmit with busy request and dropped line byte
    queue_req(FN_READ, 8'hFF, 1'b1);
    queue_req(FN_LINE, START_CODE, 1'b0);
    queue_req(FN_LINE, 8'd3, 1'b0);
    queue_req(FN_LINE, 8'hFC, 1'b0);
    queue_req(FN_READ, 8'h00, 1'b0);
    queue_req(FN_LINE, START_CODE, 1'b0);
    queue_req(FN_LINE, 8'd2, 1'b0);
    queue_req(FN_LINE, 8'hFF, 1'b1);
    queue_req(FN_READ, 8'h00, 1'b0);
    rx_frame(5, 1'b1, 0);
    queue_req(FN_TX, 8'hFF, 1'b0);
    queue_req(FN_TX, 8'h00, 1'b1);
    queue_req(FN_TX, 8'h12, 1'b0);
    queue_req(FN_LINE, 8'hAA, 1'b0);
    queue_req(FN_LINE, ACK_CODE, 1'b0);
    drain();

    // length above max_frame_len, timeout on a tick, timeout on a line byte
    set_link(3, 10);
    queue_req(FN_LINE, START_CODE, 1'b0);
    queue_req(FN_LINE, 8'd11, 1'b0);
    queue_req(FN_READ, 8'h00, 1'b0);
    queue_req(FN_LINE, START_CODE, 1'b0);
    queue_req(FN_LINE, 8'd5, 1'b0);
    repeat (4) queue_req(FN_TICK, 8'h00, 1'b0);
    queue_req(FN_READ, 8'h00, 1'b0);
    queue_req(FN_LINE, START_CODE, 1'b0);
    queue_req(FN_LINE, 8'd4, 1'b0);
    queue_req(FN_TX, 8'h80, 1'b1);
    repeat (4) queue_req(FN_TICK, 8'h00, 1'b0);
    queue_req(FN_LINE, ACK_CODE, 1'b0);
    queue_req(FN_LINE, 8'h00, 1'b0);
    queue_req(FN_READ, 8'h00, 1'b0);
    drain();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          set_link(1, 3);
          gaps_on  = 1'b1;
          stall_on = 1'b1;
        end
        1: begin
          set_link(ELAPSED_MAX, 64);
          gaps_on  = 1'b0;
          stall_on = 1'b0;
        end
        2: begin
          set_link($urandom_range(2, 24), $urandom_range(3, 64));
          gaps_on  = 1'b1;
          stall_on = 1'b1;
        end
        3: begin
          set_link($urandom_range(2, 24), 64);
          gaps_on  = 1'b0;
          stall_on = 1'b1;
        end
        default: begin
          set_link(TMO_RESET, $urandom_range(20, 64));
          gaps_on  = 1'b1;
          stall_on = 1'b0;
        end
      endcase
      phase_start = n_fed;
      if (ph == 1) begin
        // receiver holds off while requests keep coming, so the block backs up
        hold_asks++;
        for (i = 0; i < 12; i++) begin
          queue_req(FN_READ, 8'($urandom), 1'($urandom));
        end
        rx_frame(8, 1'b0, 0);
        tx_frame(6, 1, 0);
      end
      while (n_fed - phase_start < PHASE_ITEMS) begin
        random_sequence();
      end
      drain();
    end

    repeat (150) @(posedge clk);
    if (mismatch_cnt == 0 && link_out_q.size() == 0) begin
      $display("ack_handshake_frame_link_core test passed");
    end else begin
      $display("ack_handshake_frame_link_core test failed");
    end
    $finish;
  end

endmodule
